[sv/rcsp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcsp_pkg: shared types and constants of the RESP command parser
// Byte classes, result word layout, result and error codes, reset values.
// ----------------------------------------------------------------------------
package rcsp_pkg;

  localparam int COUNT_BITS_DEF = 16;
  localparam int LEN_BITS_DEF   = 30;
  localparam int QUEUE_DEPTH    = 2;

  localparam int IDX_W   = 16;
  localparam int LEN_W   = 30;
  localparam int MAXA_W  = 16;
  localparam int MAXL_W  = 30;

  localparam logic [MAXA_W-1:0] MAX_ARGS_RESET     = 16'd1024;
  localparam logic [MAXL_W-1:0] MAX_BULK_LEN_RESET = 30'd536870912;

  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  typedef enum logic [2:0] {
    CLS_DIGIT,
    CLS_STAR,
    CLS_DOLLAR,
    CLS_CR,
    CLS_LF,
    CLS_OTHER
  } byte_cls_t;

  typedef struct packed {
    logic [7:0] data;
    byte_cls_t  cls;
    logic [3:0] digit;
  } cls_word_t;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_ARGDONE = 2'd1,
    KIND_EMPTY   = 2'd2,
    KIND_ERROR   = 2'd3
  } res_kind_t;

  typedef enum logic [1:0] {
    ERR_MARKER = 2'd0,
    ERR_NUMBER = 2'd1,
    ERR_CRLF   = 2'd2,
    ERR_LIMIT  = 2'd3
  } err_kind_t;

  typedef struct packed {
    res_kind_t        kind;
    logic [7:0]       data;
    logic [IDX_W-1:0] idx;
    logic [LEN_W-1:0] len;
    logic             last;
    err_kind_t        err;
  } res_word_t;

  // Status of a queue as seen by the side that drains it
  typedef struct packed {
    logic valid;
    logic pop;
  } q_ctl_t;

endpackage

[sv/resp_command_stream_parser_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// resp_command_stream_parser_unit: RESP array-of-bulk-strings parser
// Byte-wide parser for '*count CRLF ($len CRLF payload CRLF)*' commands.
// ----------------------------------------------------------------------------
// Takes one byte of the command stream per cycle and keeps that rate for as
// long as results are popped: each byte costs one pass through the parser
// engine, whose longest path is the saturating times-ten add of the number
// accumulator. Each word shows (empty low) once it is in the result queue.
// Payload bytes come out one word each, tagged with their argument index;
// the closing CR LF of an argument gives an argument-done word with its
// length and a last flag; '*0' gives an empty-command word; any malformed
// byte gives one error word and the parser waits for '*' again. Limits
// max_args (0x0) and max_bulk_len (0x4) are to be written over the APB
// port only while the stream is idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module resp_command_stream_parser_unit #(
  parameter int COUNT_BITS = rcsp_pkg::COUNT_BITS_DEF,
  parameter int LEN_BITS   = rcsp_pkg::LEN_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // byte intake
  input  logic        push,
  input  logic [7:0]  in_byte,
  output logic        full,
  // result words
  input  logic        pop,
  output logic        empty,
  output logic [1:0]  out_kind,
  output logic [7:0]  data_byte,
  output logic [15:0] arg_index,
  output logic [29:0] arg_length,
  output logic        last_arg,
  output logic [1:0]  error_kind,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import rcsp_pkg::*;

  localparam logic REG_MAX_ARGS     = 1'b0;
  localparam logic REG_MAX_BULK_LEN = 1'b1;

  logic [MAXA_W-1:0] max_args;
  logic [MAXL_W-1:0] max_bulk_len;
  logic              cfg_wr;

  cls_word_t cls_word;
  logic      cls_valid;
  logic      cls_pop;
  q_ctl_t    in_ctl;
  res_word_t res_word;
  logic      res_push;
  logic      res_full;

  // Limit registers; one wait-free APB slave
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_args     <= MAX_ARGS_RESET;
      max_bulk_len <= MAX_BULK_LEN_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_MAX_ARGS:     max_args     <= pwdata[MAXA_W-1:0];
        REG_MAX_BULK_LEN: max_bulk_len <= pwdata[MAXL_W-1:0];
        default:          max_args     <= max_args;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_MAX_ARGS:     prdata = {16'b0, max_args};
      REG_MAX_BULK_LEN: prdata = {2'b0, max_bulk_len};
      default:          prdata = '0;
    endcase
  end

  // Front: classify and queue incoming bytes
  rcsp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .in_byte   (in_byte),
    .full      (full),
    .cls_pop   (cls_pop),
    .cls_valid (cls_valid),
    .cls_word  (cls_word)
  );

  assign in_ctl.valid = cls_valid;
  assign in_ctl.pop   = cls_pop;

  // Back: grammar engine and result queue
  rcsp_back #(
    .COUNT_BITS (COUNT_BITS),
    .LEN_BITS   (LEN_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .in_ctl_i     (in_ctl),
    .cls_pop      (cls_pop),
    .cls_word     (cls_word),
    .max_args     (max_args),
    .max_bulk_len (max_bulk_len),
    .pop          (pop),
    .empty        (empty),
    .res_push     (res_push),
    .res_full     (res_full),
    .res_word     (res_word)
  );

  assign out_kind   = res_word.kind;
  assign data_byte  = res_word.data;
  assign arg_index  = res_word.idx;
  assign arg_length = res_word.len;
  assign last_arg   = res_word.last;
  assign error_kind = res_word.err;

  // Engine never drains an empty byte queue
  a_pop_has_byte: assert property (@(posedge clk) disable iff (rst)
    in_ctl.pop |-> in_ctl.valid)
    else $error("engine took a byte from an empty queue");

  // Engine never writes a word into a full result queue
  a_push_has_room: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !res_full)
    else $error("result word pushed into a full queue");

  // Only payload words carry a data byte
  a_data_only_payload: assert property (@(posedge clk) disable iff (rst)
    (!empty && out_kind != KIND_PAYLOAD) |-> (data_byte == 8'd0))
    else $error("data byte on a word that is not payload");

  // Both queues come out of reset empty
  a_reset_empty: assert property (@(posedge clk)
    $fell(rst) |-> (empty && !full))
    else $error("queues not empty after reset");

endmodule

[sv/rcsp_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcsp_queue: small synchronous queue
// Register-file queue with occupancy count; push on full and pop on empty
// are ignored.
// ----------------------------------------------------------------------------
module rcsp_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    rd_ptr;
  logic [PW-1:0]    wr_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

[sv/rcsp_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcsp_front: byte intake and classification
// Tags each incoming byte with its class and digit value and holds it in
// the decoupling queue towards the parser engine.
// ----------------------------------------------------------------------------
module rcsp_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  logic [7:0]         in_byte,
  output logic               full,
  input  logic               cls_pop,
  output logic               cls_valid,
  output rcsp_pkg::cls_word_t cls_word
);
  import rcsp_pkg::*;

  cls_word_t cw;
  logic      q_empty;

  always_comb begin
    cw.data  = in_byte;
    cw.digit = 4'(in_byte - CH_ZERO);
    if (in_byte >= CH_ZERO && in_byte <= CH_NINE) begin
      cw.cls = CLS_DIGIT;
    end else if (in_byte == CH_STAR) begin
      cw.cls = CLS_STAR;
    end else if (in_byte == CH_DOLLAR) begin
      cw.cls = CLS_DOLLAR;
    end else if (in_byte == CH_CR) begin
      cw.cls = CLS_CR;
    end else if (in_byte == CH_LF) begin
      cw.cls = CLS_LF;
    end else begin
      cw.cls = CLS_OTHER;
    end
  end

  rcsp_queue #(
    .WIDTH ($bits(cls_word_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_cls_q (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (cw),
    .full  (full),
    .pop   (cls_pop),
    .rdata (cls_word),
    .empty (q_empty)
  );

  assign cls_valid = !q_empty;

endmodule

[sv/rcsp_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcsp_back: parser engine and result queue
// Walks the RESP grammar one classified byte per cycle while the result
// queue has room and queues the resulting words for the output side.
// ----------------------------------------------------------------------------
module rcsp_back #(
  parameter int COUNT_BITS = rcsp_pkg::COUNT_BITS_DEF,
  parameter int LEN_BITS   = rcsp_pkg::LEN_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  rcsp_pkg::q_ctl_t                  in_ctl_i,
  output logic                              cls_pop,
  input  rcsp_pkg::cls_word_t               cls_word,
  input  logic [rcsp_pkg::MAXA_W-1:0]       max_args,
  input  logic [rcsp_pkg::MAXL_W-1:0]       max_bulk_len,
  input  logic                              pop,
  output logic                              empty,
  output logic                              res_push,
  output logic                              res_full,
  output rcsp_pkg::res_word_t               res_word
);
  import rcsp_pkg::*;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_COUNT,
    PH_COUNT_LF,
    PH_DOLLAR,
    PH_LEN,
    PH_LEN_LF,
    PH_DATA,
    PH_DATA_CR,
    PH_DATA_LF
  } phase_t;

  phase_t                phase, phase_next;
  logic [31:0]           accum, accum_next;
  logic                  digit_seen, digit_seen_next;
  logic [COUNT_BITS-1:0] args_total, args_total_next;
  logic [COUNT_BITS-1:0] current_arg, current_arg_next;
  logic [LEN_BITS-1:0]   bytes_left, bytes_left_next;
  logic [LEN_BITS-1:0]   current_len, current_len_next;

  logic        take;
  logic        go_idle;
  logic [35:0] prod;
  logic        count_lim;
  logic        len_lim;
  logic        is_last;
  res_word_t   res_d;

  assign take    = in_ctl_i.valid && !res_full;
  assign cls_pop = take;

  // accum * 10 + digit, saturating at all ones
  assign prod = ({4'b0, accum} << 3) + ({4'b0, accum} << 1) + 36'(cls_word.digit);

  assign count_lim = (accum > {16'b0, max_args}) || (|(accum >> COUNT_BITS));
  assign len_lim   = (accum > {2'b0, max_bulk_len}) || (|(accum >> LEN_BITS));
  assign is_last   = ({1'b0, current_arg} + 1'b1) >= {1'b0, args_total};

  always_comb begin
    phase_next       = phase;
    accum_next       = accum;
    digit_seen_next  = digit_seen;
    args_total_next  = args_total;
    current_arg_next = current_arg;
    bytes_left_next  = bytes_left;
    current_len_next = current_len;
    go_idle          = 1'b0;
    res_push         = 1'b0;
    res_d.kind       = KIND_PAYLOAD;
    res_d.data       = '0;
    res_d.idx        = '0;
    res_d.len        = '0;
    res_d.last       = 1'b0;
    res_d.err        = ERR_MARKER;

    if (take) begin
      case (phase)
        PH_IDLE, PH_DOLLAR: begin
          if ((phase == PH_IDLE && cls_word.cls == CLS_STAR) ||
              (phase == PH_DOLLAR && cls_word.cls == CLS_DOLLAR)) begin
            accum_next      = '0;
            digit_seen_next = 1'b0;
            phase_next      = (phase == PH_IDLE) ? PH_COUNT : PH_LEN;
          end else begin
            res_push  = 1'b1;
            res_d.err = ERR_MARKER;
          end
        end
        PH_COUNT, PH_LEN: begin
          if (cls_word.cls == CLS_DIGIT) begin
            accum_next      = (|prod[35:32]) ? '1 : prod[31:0];
            digit_seen_next = 1'b1;
          end else if (cls_word.cls != CLS_CR || !digit_seen) begin
            res_push  = 1'b1;
            res_d.err = ERR_NUMBER;
          end else if ((phase == PH_COUNT) ? count_lim : len_lim) begin
            res_push  = 1'b1;
            res_d.err = ERR_LIMIT;
          end else begin
            phase_next = (phase == PH_COUNT) ? PH_COUNT_LF : PH_LEN_LF;
          end
        end
        PH_COUNT_LF: begin
          if (cls_word.cls != CLS_LF) begin
            res_push  = 1'b1;
            res_d.err = ERR_CRLF;
          end else if (accum == '0) begin
            res_push   = 1'b1;
            res_d.kind = KIND_EMPTY;
            go_idle    = 1'b1;
          end else begin
            args_total_next  = accum[COUNT_BITS-1:0];
            current_arg_next = '0;
            phase_next       = PH_DOLLAR;
          end
        end
        PH_LEN_LF: begin
          if (cls_word.cls != CLS_LF) begin
            res_push  = 1'b1;
            res_d.err = ERR_CRLF;
          end else begin
            current_len_next = accum[LEN_BITS-1:0];
            bytes_left_next  = accum[LEN_BITS-1:0];
            phase_next = (accum[LEN_BITS-1:0] == '0) ? PH_DATA_CR : PH_DATA;
          end
        end
        PH_DATA: begin
          res_push        = 1'b1;
          res_d.kind      = KIND_PAYLOAD;
          res_d.data      = cls_word.data;
          res_d.idx       = IDX_W'(current_arg);
          bytes_left_next = bytes_left - 1'b1;
          if (bytes_left == LEN_BITS'(1)) begin
            phase_next = PH_DATA_CR;
          end
        end
        PH_DATA_CR: begin
          if (cls_word.cls != CLS_CR) begin
            res_push  = 1'b1;
            res_d.err = ERR_CRLF;
          end else begin
            phase_next = PH_DATA_LF;
          end
        end
        PH_DATA_LF: begin
          if (cls_word.cls != CLS_LF) begin
            res_push  = 1'b1;
            res_d.err = ERR_CRLF;
          end else begin
            res_push   = 1'b1;
            res_d.kind = KIND_ARGDONE;
            res_d.idx  = IDX_W'(current_arg);
            res_d.len  = LEN_W'(current_len);
            res_d.last = is_last;
            if (is_last) begin
              go_idle = 1'b1;
            end else begin
              current_arg_next = current_arg + 1'b1;
              phase_next       = PH_DOLLAR;
            end
          end
        end
        default: begin
          go_idle = 1'b1;
        end
      endcase

      // every byte that raises a fault lands here: tag it and drop back to idle
      if (res_push && res_d.kind == KIND_PAYLOAD && phase != PH_DATA) begin
        res_d.kind = KIND_ERROR;
        res_d.idx  = IDX_W'(current_arg);
        go_idle    = 1'b1;
      end
    end

    if (go_idle) begin
      phase_next       = PH_IDLE;
      accum_next       = '0;
      digit_seen_next  = 1'b0;
      args_total_next  = '0;
      current_arg_next = '0;
      bytes_left_next  = '0;
      current_len_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      accum       <= '0;
      digit_seen  <= 1'b0;
      args_total  <= '0;
      current_arg <= '0;
      bytes_left  <= '0;
      current_len <= '0;
    end else begin
      phase       <= phase_next;
      accum       <= accum_next;
      digit_seen  <= digit_seen_next;
      args_total  <= args_total_next;
      current_arg <= current_arg_next;
      bytes_left  <= bytes_left_next;
      current_len <= current_len_next;
    end
  end

  rcsp_queue #(
    .WIDTH ($bits(res_word_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res_d),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_word),
    .empty (empty)
  );

endmodule
